// File: design/ida_pkg.sv
// ----------------------------------------------------------------------------
// ida_pkg
// Constants and pipeline stage types for the directed-rounding binary64 adder.
// ----------------------------------------------------------------------------
`default_nettype none
package ida_pkg;

  localparam logic [63:0] SignBit = 64'h8000000000000000;
  localparam logic [62:0] ExpMask = 63'h7FF0000000000000;
  localparam logic [63:0] QNan    = 64'h7FF8000000000000;
  localparam logic [62:0] MaxFin  = 63'h7FEFFFFFFFFFFFFF;
  localparam int unsigned XBits   = 9;

  // special-result handling carried down the pipe
  typedef struct packed {
    logic        special;
    logic [63:0] value;
  } spec_t;

  // after operand ordering
  typedef struct packed {
    spec_t       spec;
    logic        sa;
    logic        sb;
    logic [10:0] ea;
    logic [10:0] eb;
    logic [62:0] sig_a;
    logic [62:0] sig_b;
  } s1_t;

  // after alignment and add/subtract
  typedef struct packed {
    spec_t       spec;
    logic        neg;
    logic        zero_diff;
    logic        zero_same;
    logic [11:0] e;
    logic [62:0] m;
  } s2_t;

  // after normalization
  typedef struct packed {
    spec_t       spec;
    logic        neg;
    logic        zero_diff;
    logic        zero_same;
    logic [11:0] e;
    logic [53:0] keep;
    logic        inexact;
  } s3_t;

endpackage
`default_nettype wire

// File: design/interval_double_adder_core.sv
// ----------------------------------------------------------------------------
// interval_double_adder_core
// Adds two binary64 operands, rounded toward +inf and toward -inf.
// ----------------------------------------------------------------------------
// Usage:
//   Drive addend_a_i/addend_b_i and raise start_i; the transaction is taken at
//   the clock edge where start_i is high (busy_o is always low, the pipe never
//   stalls). One transaction may be issued every cycle.
//   Four register stages: unpack/order, align/add, normalize, round/pack.
//   The result appears on sum_upper_o/sum_lower_o with done_o high for one
//   cycle, once the transaction has passed registers s1_q, s2_q, s3_q and
//   up_q/lo_q. Throughput is one transaction per cycle, since every stage takes
//   a new transaction each cycle.
//   The receiver cannot stall; results are shown once and are not held.
//   Reset clears all stage valid bits; data registers are not reset.
//   NaN operands or inf-inf give the quiet NaN 0x7FF8000000000000.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_double_adder_core
  import ida_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [63:0] addend_a_i,
  input  wire logic [63:0] addend_b_i,
  output logic             done_o,
  output logic [63:0]      sum_upper_o,
  output logic [63:0]      sum_lower_o
);

  logic [3:0] vld_q, vld_d;
  s1_t s1_q, s1_d;
  s2_t s2_q, s2_d;
  s3_t s3_q, s3_d;
  logic [63:0] up_q, up_d, lo_q, lo_d;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[2:0], start_i};

  // stage 1: classify, order by magnitude
  always_comb begin
    logic [62:0] ma, mb;
    logic        swap;
    logic [63:0] a, b;
    ma = addend_a_i[62:0];
    mb = addend_b_i[62:0];
    s1_d.spec.special = 1'b0;
    s1_d.spec.value   = QNan;
    if (ma > ExpMask || mb > ExpMask) begin
      s1_d.spec.special = 1'b1;
    end else if (ma == ExpMask || mb == ExpMask) begin
      s1_d.spec.special = 1'b1;
      if (!(ma == ExpMask && mb == ExpMask && addend_a_i[63] != addend_b_i[63])) begin
        s1_d.spec.value = (ma == ExpMask) ? addend_a_i : addend_b_i;
      end
    end
    swap = mb > ma;
    a = swap ? addend_b_i : addend_a_i;
    b = swap ? addend_a_i : addend_b_i;
    s1_d.sa = a[63];
    s1_d.sb = b[63];
    s1_d.ea = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
    s1_d.eb = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
    s1_d.sig_a = {1'b0, a[62:52] != 11'd0, a[51:0], 9'd0};
    s1_d.sig_b = {1'b0, b[62:52] != 11'd0, b[51:0], 9'd0};
  end

  // stage 2: align with sticky, add or subtract
  always_comb begin
    logic [10:0] d;
    logic [62:0] sb, lost_mask;
    d = s1_q.ea - s1_q.eb;
    sb = s1_q.sig_b;
    lost_mask = '0;
    if (d >= 11'd63) begin
      sb = {62'd0, s1_q.sig_b != 63'd0};
    end else if (d != 11'd0) begin
      lost_mask = ~(63'h7FFFFFFFFFFFFFFF << d[5:0]);
      sb = (s1_q.sig_b >> d[5:0]) | {62'd0, (s1_q.sig_b & lost_mask) != 63'd0};
    end
    s2_d.spec = s1_q.spec;
    s2_d.neg  = s1_q.sa;
    s2_d.e    = {1'b0, s1_q.ea};
    if (s1_q.sa == s1_q.sb) begin
      s2_d.m = s1_q.sig_a + sb;
    end else begin
      s2_d.m = s1_q.sig_a - sb;
    end
    s2_d.zero_diff = (s1_q.sa != s1_q.sb) && (s2_d.m == 63'd0);
    s2_d.zero_same = (s1_q.sa == s1_q.sb) && (s2_d.m == 63'd0);
  end

  // stage 3: normalize
  always_comb begin
    logic [62:0] m;
    logic [11:0] e;
    logic [5:0]  lz, sh;
    logic        found;
    m = s2_q.m;
    e = s2_q.e;
    lz = 6'd0;
    sh = 6'd0;
    found = 1'b0;
    for (int i = 61; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        lz = 6'(61 - i);
      end
    end
    if (m[62]) begin
      m = {1'b0, m[62:2], m[1] | m[0]};
      e = e + 12'd1;
    end else begin
      sh = (12'(lz) > e - 12'd1) ? 6'(e - 12'd1) : lz;
      m = m << sh;
      e = e - 12'(sh);
    end
    s3_d.spec      = s2_q.spec;
    s3_d.neg       = s2_q.neg;
    s3_d.zero_diff = s2_q.zero_diff;
    s3_d.zero_same = s2_q.zero_same;
    s3_d.e         = e;
    s3_d.keep      = m[62:XBits];
    s3_d.inexact   = m[XBits-1:0] != '0;
  end

  // stage 4: round both ways, pack
  function automatic logic [63:0] pack_dir(input s3_t s, input logic toward_inf);
    logic [53:0] k;
    logic [11:0] e;
    logic [62:0] t;
    k = s.keep + {53'd0, s.inexact && toward_inf};
    e = s.e;
    if (k[53]) begin
      k = k >> 1;
      e = e + 12'd1;
    end
    if (e >= 12'd2047) begin
      t = toward_inf ? ExpMask : MaxFin;
    end else begin
      t = {k[52] ? e[10:0] : 11'd0, k[51:0]};
    end
    return {s.neg, t};
  endfunction

  always_comb begin
    if (s3_q.spec.special) begin
      up_d = s3_q.spec.value;
      lo_d = s3_q.spec.value;
    end else if (s3_q.zero_diff) begin
      up_d = 64'd0;
      lo_d = SignBit;
    end else if (s3_q.zero_same) begin
      up_d = {s3_q.neg, 63'd0};
      lo_d = {s3_q.neg, 63'd0};
    end else begin
      up_d = pack_dir(s3_q, !s3_q.neg);
      lo_d = pack_dir(s3_q, s3_q.neg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
    up_q <= up_d;
    lo_q <= lo_d;
  end

  assign done_o      = vld_q[3];
  assign sum_upper_o = up_q;
  assign sum_lower_o = lo_q;

endmodule
`default_nettype wire
